### sv/binary_to_decimal_ascii_assert.svh
// Assertion macros for the converter, clocked by clk and disabled while arst_n is low.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/b2da_pkg.sv
package b2da_pkg;

	localparam int unsigned BIN_W      = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned CNT_W      = $clog2(BIN_W);
	localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);
	localparam int unsigned CHAR_W     = 6;

	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(BIN_W - 1);
	localparam logic [REM_W-1:0]  REM_FULL   = REM_W'(NUM_DIGITS);
	localparam logic [REM_W-1:0]  REM_ONE    = REM_W'(1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Double-dabble correction of one BCD digit before it is shifted left.
	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage

### sv/binary_to_decimal_ascii.sv
// Flow: a number is accepted in idle and run through the 32-step shift loop; the digit
// scan then steps through the 10 digit positions, skipping leading zeros, and sends the
// digits one per cycle unless the output stalls. A new number is taken only once the
// block is back in idle.
// Reset: arst_n clears the state machine and the output valid at once.
`include "binary_to_decimal_ascii_assert.svh"
module binary_to_decimal_ascii (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [b2da_pkg::BIN_W-1:0]       number,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
	output logic                             last
);
	import b2da_pkg::*;

	state_t               state_q, state_d;
	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q, bcd_adj;
	logic [CNT_W-1:0]     cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 started_q;
	logic                 out_valid_q, last_q;
	logic [CHAR_W-1:0]    digit_char_q;
	logic [3:0]           top_digit;
	logic                 out_free, skip, take, load;

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = bcd_adjust(bcd_q[4*i +: 4]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CNT_LAST) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (take && rem_q == REM_ONE) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		load     = 1'b0;
		skip     = 1'b0;
		take     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				load     = in_valid;
			end
			ST_CONV: begin
			end
			ST_EMIT: begin
				skip = !started_q && top_digit == 4'd0 && rem_q != REM_ONE;
				take = !skip && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= number;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q     <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q     <= {bin_q[BIN_W-2:0], 1'b0};
			cnt_q     <= cnt_q + CNT_W'(1);
			rem_q     <= REM_FULL;
			started_q <= 1'b0;
		end else if (skip || take) begin
			bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
			rem_q     <= rem_q - REM_ONE;
			started_q <= started_q || take;
		end
		if (take) begin
			digit_char_q <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
			last_q       <= (rem_q == REM_ONE);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	// A sent character is always a decimal digit.
	`B2DA_ASSERT_NOW(a_digit_is_decimal, out_valid,
		digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE,
		"Output character is not a decimal digit.")
	// The conversion hands over to the output phase with all digits pending.
	`B2DA_ASSERT_NEXT(a_conv_done, state_q == ST_CONV && cnt_q == CNT_LAST,
		state_q == ST_EMIT && rem_q == REM_FULL,
		"Conversion did not finish after the last shift.")
	// Sending the final digit returns the block to idle and marks the transaction last.
	`B2DA_ASSERT_NEXT(a_final_digit, take && rem_q == REM_ONE,
		state_q == ST_IDLE && out_valid && last,
		"Final digit did not end the transaction.")

endmodule
